### sv/kns_pkg.sv
// Package for the key scan note event generator.
// Holds shared widths, register indexes and the lane status type.
// No dependencies.
`default_nettype none

package kns_pkg;

   // Key count
   localparam int NUM_KEYS_DEFAULT = 12;
   localparam int MAX_KEYS         = 32;

   // Field widths
   localparam int CHANNEL_W = 8;
   localparam int PITCH_W   = 7;
   localparam int OCT_W     = 4;
   localparam int BASE_W    = 10;

   // Pitch and octave limits
   localparam int PITCH_MAX  = 127;
   localparam int OCT_MAX    = 4;
   localparam int OCT_MIN    = -4;
   localparam int ROOT_RESET = 60;

   // Control register port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_NOTE = 1'd1;

   // What one key lane reports to the merge stage
   typedef struct packed {
      logic                 pend;
      logic                 note_on;
      logic                 held;
      logic [CHANNEL_W-1:0] channel;
      logic [PITCH_W-1:0]   pitch;
   } lane_status_type;

endpackage

`default_nettype wire

### sv/kns_req_if.sv
// Scan tick channel: valid/ready handshake and one tick word.
// Depends on kns_pkg.
`default_nettype none

interface kns_req_if
   import kns_pkg::*;
#(
   parameter int NUM_KEYS = NUM_KEYS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [NUM_KEYS-1:0]  key_down_mask;
   logic                 octave_up_key;
   logic                 octave_down_key;
   logic                 host_blocked;
   logic                 channel_valid;
   logic [CHANNEL_W-1:0] channel;

   modport source (
      output valid, key_down_mask, octave_up_key, octave_down_key,
             host_blocked, channel_valid, channel,
      input  ready
   );
   modport sink (
      input  valid, key_down_mask, octave_up_key, octave_down_key,
             host_blocked, channel_valid, channel,
      output ready
   );
endinterface

`default_nettype wire

### sv/kns_rsp_if.sv
// Note event channel: valid/ready handshake and one event word.
// Depends on kns_pkg.
`default_nettype none

interface kns_rsp_if
   import kns_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic                 note_on;
   logic [CHANNEL_W-1:0] event_channel;
   logic [PITCH_W-1:0]   event_pitch;
   logic                 last;

   modport source (
      output valid, note_on, event_channel, event_pitch, last,
      input  ready
   );
   modport sink (
      input  valid, note_on, event_channel, event_pitch, last,
      output ready
   );
endinterface

`default_nettype wire

### sv/kns_lane.sv
// One note key lane: key history, held note and the pending event flag.
// Depends on kns_pkg.
`default_nettype none

module kns_lane
   import kns_pkg::*;
#(
   parameter int LANE = 0
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     tick,
   input  wire logic                     release_all,
   input  wire logic                     key_down,
   input  wire logic [CHANNEL_W-1:0]     channel,
   input  wire logic signed [BASE_W-1:0] base_pitch,
   input  wire logic                     take,
   output lane_status_type               status
);

   logic                 key_hist_ff, key_hist_in;
   logic                 held_ff, held_in;
   logic                 pend_ff, pend_in;
   logic                 on_ff, on_in;
   logic [CHANNEL_W-1:0] channel_ff, channel_in;
   logic [PITCH_W-1:0]   pitch_ff, pitch_in;

   logic signed [BASE_W-1:0] pitch_sum;
   logic [PITCH_W-1:0]       pitch_sat;

   // Saturate root plus octave plus semitone to the note range
   always_comb begin
      pitch_sum = base_pitch + signed'(BASE_W'(LANE));
      if (pitch_sum < 0) begin
         pitch_sat = '0;
      end else if (pitch_sum > signed'(BASE_W'(PITCH_MAX))) begin
         pitch_sat = PITCH_W'(PITCH_MAX);
      end else begin
         pitch_sat = pitch_sum[PITCH_W-1:0];
      end
   end

   // Update key state on a tick; drop the pending flag once merged
   always_comb begin
      key_hist_in = key_hist_ff;
      held_in     = held_ff;
      pend_in     = pend_ff & ~take;
      on_in       = on_ff;
      channel_in  = channel_ff;
      pitch_in    = pitch_ff;
      if (tick) begin
         if (release_all) begin
            pend_in     = held_ff;
            on_in       = 1'b0;
            held_in     = 1'b0;
            key_hist_in = 1'b0;
         end else if (key_down != key_hist_ff) begin
            key_hist_in = key_down;
            if (key_down) begin
               held_in    = 1'b1;
               channel_in = channel;
               pitch_in   = pitch_sat;
               pend_in    = 1'b1;
               on_in      = 1'b1;
            end else if (held_ff) begin
               // Held channel and pitch stay as the note-off payload
               pend_in = 1'b1;
               on_in   = 1'b0;
               held_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hist_ff <= 1'b0;
         held_ff     <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         key_hist_ff <= key_hist_in;
         held_ff     <= held_in;
         pend_ff     <= pend_in;
      end
      on_ff      <= on_in;
      channel_ff <= channel_in;
      pitch_ff   <= pitch_in;
   end

   // Pack the lane state for the merge stage
   assign status = {pend_ff, on_ff, held_ff, channel_ff, pitch_ff};

endmodule

`default_nettype wire

### sv/kns_merge.sv
// Merge stage: picks the lowest pending lane into the output word each cycle the output is free or taken.
// Depends on kns_pkg and kns_rsp_if.
`default_nettype none

module kns_merge
   import kns_pkg::*;
#(
   parameter int NUM_KEYS = NUM_KEYS_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  lane_status_type      lanes [NUM_KEYS],
   output logic [NUM_KEYS-1:0]  take,
   output logic                 pend_any,
   kns_rsp_if.source            rsp
);

   logic [NUM_KEYS-1:0]  pend;
   logic [NUM_KEYS-1:0]  first;
   logic                 load;
   logic                 sel_on;
   logic [CHANNEL_W-1:0] sel_channel;
   logic [PITCH_W-1:0]   sel_pitch;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_on_ff;
   logic [CHANNEL_W-1:0] out_channel_ff;
   logic [PITCH_W-1:0]   out_pitch_ff;
   logic                 out_last_ff;

   // Gather pending flags and isolate the lowest one
   always_comb begin
      for (int i = 0; i < NUM_KEYS; i++) begin
         pend[i] = lanes[i].pend;
      end
      first = pend & (~pend + NUM_KEYS'(1));
   end

   assign pend_any = |pend;
   assign load     = pend_any && (!out_valid_ff || rsp.ready);
   assign take     = load ? first : '0;

   // One-hot select of the chosen lane
   always_comb begin
      sel_on      = 1'b0;
      sel_channel = '0;
      sel_pitch   = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (first[i]) begin
            sel_on      = sel_on | lanes[i].note_on;
            sel_channel = sel_channel | lanes[i].channel;
            sel_pitch   = sel_pitch | lanes[i].pitch;
         end
      end
   end

   // Hold the word until taken; load the next one in the same cycle
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (load) begin
         out_on_ff      <= sel_on;
         out_channel_ff <= sel_channel;
         out_pitch_ff   <= sel_pitch;
         out_last_ff    <= ((pend & ~first) == '0);
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.note_on       = out_on_ff;
   assign rsp.event_channel = out_channel_ff;
   assign rsp.event_pitch   = out_pitch_ff;
   assign rsp.last          = out_last_ff;

endmodule

`default_nettype wire

### sv/key_scan_note_event_generator_top.sv
// Top level of the key scan note event generator: control registers,
// octave shift, key lanes and the merge stage.
// Depends on kns_pkg, kns_req_if, kns_rsp_if, kns_lane and kns_merge.
//
//   channel  direction  handshake          word
//   req_bus  in         valid/ready        one scan tick
//   rsp_bus  out        valid/ready        one note event, last on final one
//   csr_*    in         write enable only  enable, root_note
//
// All key lanes update together in the cycle a tick is taken.
// The merge stage then moves one event per cycle into the output register
// while that register is empty or its word is being taken.
// The next tick is taken once every pending event has left the lanes.
// Reset is synchronous: history, held flags and octave shift clear at once.
// A stalled output holds its word and the lanes keep their events pending.
`default_nettype none

module key_scan_note_event_generator_top
   import kns_pkg::*;
#(
   parameter int NUM_KEYS = NUM_KEYS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   kns_req_if.sink                     req_bus,
   kns_rsp_if.source                   rsp_bus,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic                 enable_ff, enable_in;
   logic [PITCH_W-1:0]   root_ff, root_in;
   logic signed [OCT_W-1:0] octave_ff, octave_in;
   logic                 up_hist_ff, up_hist_in;
   logic                 down_hist_ff, down_hist_in;

   logic                     tick;
   logic                     release_all;
   logic signed [BASE_W-1:0] octave_ext;
   logic signed [BASE_W-1:0] base_pitch;
   logic [NUM_KEYS-1:0]      take;
   logic [NUM_KEYS-1:0]      held;
   logic                     pend_any;
   lane_status_type          lanes [NUM_KEYS];

   // Accept a tick only when no event is left in the lanes
   assign req_bus.ready = !pend_any;
   assign tick          = req_bus.valid && req_bus.ready;
   assign release_all   = !enable_ff || req_bus.host_blocked || !req_bus.channel_valid;

   // Control register writes
   always_comb begin
      enable_in = enable_ff;
      root_in   = root_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE:    enable_in = csr_write_data[0];
            CSR_ROOT_NOTE: root_in   = csr_write_data[PITCH_W-1:0];
            default:       ;
         endcase
      end
   end

   // Edge-detect the octave keys and saturate the shift; up goes first
   always_comb begin
      octave_in    = octave_ff;
      up_hist_in   = up_hist_ff;
      down_hist_in = down_hist_ff;
      if (tick && !release_all) begin
         if (req_bus.octave_up_key && !up_hist_ff &&
             octave_in != signed'(OCT_W'(OCT_MAX))) begin
            octave_in = octave_in + signed'(OCT_W'(1));
         end
         if (req_bus.octave_down_key && !down_hist_ff &&
             octave_in != signed'(OCT_W'(OCT_MIN))) begin
            octave_in = octave_in - signed'(OCT_W'(1));
         end
         up_hist_in   = req_bus.octave_up_key;
         down_hist_in = req_bus.octave_down_key;
      end
   end

   // Pitch of key zero: root plus twelve times the new shift
   assign octave_ext = BASE_W'(octave_in);
   assign base_pitch = signed'({{(BASE_W-PITCH_W){1'b0}}, root_ff})
                       + (octave_ext <<< 3) + (octave_ext <<< 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         root_ff      <= PITCH_W'(ROOT_RESET);
         octave_ff    <= '0;
         up_hist_ff   <= 1'b0;
         down_hist_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         root_ff      <= root_in;
         octave_ff    <= octave_in;
         up_hist_ff   <= up_hist_in;
         down_hist_ff <= down_hist_in;
      end
   end

   // Key lanes
   for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
      kns_lane #(
         .LANE (g)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .tick        (tick),
         .release_all (release_all),
         .key_down    (req_bus.key_down_mask[g]),
         .channel     (req_bus.channel),
         .base_pitch  (base_pitch),
         .take        (take[g]),
         .status      (lanes[g])
      );
      assign held[g] = lanes[g].held;
   end

   kns_merge #(
      .NUM_KEYS (NUM_KEYS)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .lanes    (lanes),
      .take     (take),
      .pend_any (pend_any),
      .rsp      (rsp_bus)
   );

   // Shift never leaves its saturation range
   a_octave_range: assert property (@(posedge clock) disable iff (reset)
      octave_ff <= signed'(OCT_W'(OCT_MAX)) && octave_ff >= signed'(OCT_W'(OCT_MIN)))
      else $error("octave shift out of range");

   // A releasing tick leaves no note held
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      tick && release_all |=> held == '0)
      else $error("held note survived a release tick");

   // A stalled event word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid &&
         $stable({rsp_bus.note_on, rsp_bus.event_channel, rsp_bus.event_pitch,
                  rsp_bus.last}))
      else $error("event word changed while stalled");

   // The merge stage never takes while a tick is being accepted
   a_no_take_on_tick: assert property (@(posedge clock) disable iff (reset)
      tick |-> take == '0)
      else $error("lane taken during tick accept");

endmodule

`default_nettype wire

### tb/sv/kns_note_tracker.sv
// Scoreboard for the key scan note event generator: watches the tick and event
// channels and the control register port, predicts every note event and checks it.
// Depends on kns_pkg, kns_req_if and kns_rsp_if.
`default_nettype none

module kns_note_tracker
   import kns_pkg::*;
#(
   parameter int NUM_KEYS = NUM_KEYS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   kns_req_if                          req_bus,
   kns_rsp_if                          rsp_bus,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                          fail_count,
   output int                          pending_count
);

   typedef struct packed {
      logic                 note_on;
      logic [CHANNEL_W-1:0] channel;
      logic [PITCH_W-1:0]   pitch;
      logic                 last;
   } note_event_type;

   // Events owed by the block, oldest first
   note_event_type due_events[$];

   // Shadow of the control registers
   logic               enable_reg;
   logic [PITCH_W-1:0] root_reg;

   // Shadow of the key and octave state
   logic [NUM_KEYS-1:0]  key_seen;
   logic [NUM_KEYS-1:0]  note_held;
   logic [CHANNEL_W-1:0] held_chan [NUM_KEYS];
   logic [PITCH_W-1:0]   held_pitch [NUM_KEYS];
   int                   octave_shift;
   logic                 up_seen;
   logic                 down_seen;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Work out the events of one scan tick and append them to the due list
   task automatic predict_tick_events(
      input logic [NUM_KEYS-1:0]  mask,
      input logic                 up,
      input logic                 dn,
      input logic                 blk,
      input logic                 chv,
      input logic [CHANNEL_W-1:0] chan
   );
      note_event_type tick_events[$];
      note_event_type ev;
      int             pitch_int;
      if (!enable_reg || blk || !chv) begin
         // Release every held note in key order and forget the keys
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (note_held[k]) begin
               ev = '{1'b0, held_chan[k], held_pitch[k], 1'b0};
               tick_events.push_back(ev);
            end
         end
         note_held = '0;
         key_seen  = '0;
      end else begin
         // Edge-detect the octave keys, up before down, saturate the shift
         if (up && !up_seen) begin
            octave_shift = (octave_shift < OCT_MAX) ? octave_shift + 1 : OCT_MAX;
         end
         if (dn && !down_seen) begin
            octave_shift = (octave_shift > OCT_MIN) ? octave_shift - 1 : OCT_MIN;
         end
         up_seen   = up;
         down_seen = dn;
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (mask[k] != key_seen[k]) begin
               key_seen[k] = mask[k];
               if (mask[k]) begin
                  pitch_int = int'(root_reg) + octave_shift * 12 + k;
                  if (pitch_int < 0) begin
                     pitch_int = 0;
                  end else if (pitch_int > PITCH_MAX) begin
                     pitch_int = PITCH_MAX;
                  end
                  note_held[k]  = 1'b1;
                  held_chan[k]  = chan;
                  held_pitch[k] = PITCH_W'(pitch_int);
                  ev = '{1'b1, chan, PITCH_W'(pitch_int), 1'b0};
                  tick_events.push_back(ev);
               end else if (note_held[k]) begin
                  ev = '{1'b0, held_chan[k], held_pitch[k], 1'b0};
                  tick_events.push_back(ev);
                  note_held[k] = 1'b0;
               end
            end
         end
      end
      // Flag the final event of the tick
      foreach (tick_events[n]) begin
         ev = tick_events[n];
         ev.last = (n == tick_events.size() - 1);
         due_events.push_back(ev);
      end
   endtask

   // Compare one accepted event word with the oldest due event
   task automatic check_event_word();
      note_event_type got;
      note_event_type want;
      got = '{rsp_bus.note_on, rsp_bus.event_channel, rsp_bus.event_pitch, rsp_bus.last};
      if (due_events.size() == 0) begin
         fail_count++;
         $display("%0t: event word with none due: on=%0b ch=%0d pitch=%0d last=%0b",
                  $time, got.note_on, got.channel, got.pitch, got.last);
      end else begin
         want = due_events.pop_front();
         if (got != want) begin
            fail_count++;
            $display("%0t: event mismatch: expected on=%0b ch=%0d pitch=%0d last=%0b",
                     $time, want.note_on, want.channel, want.pitch, want.last);
            $display("%0t:                 actual   on=%0b ch=%0d pitch=%0d last=%0b",
                     $time, got.note_on, got.channel, got.pitch, got.last);
         end
      end
   endtask

   // Track registers, predict on each accepted tick, check each accepted event
   always @(posedge clock) begin
      if (reset) begin
         enable_reg   = 1'b1;
         root_reg     = PITCH_W'(ROOT_RESET);
         key_seen     = '0;
         note_held    = '0;
         octave_shift = 0;
         up_seen      = 1'b0;
         down_seen    = 1'b0;
         due_events.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ENABLE: begin
                  enable_reg = csr_write_data[0];
               end
               CSR_ROOT_NOTE: begin
                  root_reg = csr_write_data[PITCH_W-1:0];
               end
               default: begin
               end
            endcase
         end
         // Check before predicting: an event never leaves in its own tick's cycle
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_event_word();
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_tick_events(req_bus.key_down_mask, req_bus.octave_up_key,
                                req_bus.octave_down_key, req_bus.host_blocked,
                                req_bus.channel_valid, req_bus.channel);
         end
      end
      pending_count = due_events.size();
   end

endmodule

`default_nettype wire

### tb/sv/key_scan_note_event_generator_top_tb.sv
// Testbench top for the key scan note event generator: clock, reset, tick
// stimulus, event channel back-pressure, register writes and the verdict.
// Depends on kns_pkg, kns_req_if, kns_rsp_if, the block and kns_note_tracker.
`default_nettype none

module key_scan_note_event_generator_top_tb;
   import kns_pkg::*;

   localparam int NUM_KEYS     = NUM_KEYS_DEFAULT;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int SETTLE_CYCLES = NUM_KEYS + 6;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int                     fail_count;
   int                     pending_count;
   int                     cycle_count;

   // Sender and receiver pacing
   int                     sender_burst;
   int                     ready_burst;
   int                     rsp_hold_cycles;

   // Running scan state of the random part
   logic [NUM_KEYS-1:0]    scan_mask;
   logic                   scan_up;
   logic                   scan_dn;
   logic [CHANNEL_W-1:0]   scan_channel;

   kns_req_if #(.NUM_KEYS(NUM_KEYS)) req_bus ();
   kns_rsp_if                        rsp_bus ();

   key_scan_note_event_generator_top #(
      .NUM_KEYS(NUM_KEYS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   kns_note_tracker #(
      .NUM_KEYS(NUM_KEYS)
   ) u_tracker (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one tick word and hold it until accepted, then maybe idle
   task automatic send_tick(
      input logic [NUM_KEYS-1:0]  mask,
      input logic                 up,
      input logic                 dn,
      input logic                 blk,
      input logic                 chv,
      input logic [CHANNEL_W-1:0] chan
   );
      int gap;
      req_bus.valid           = 1'b1;
      req_bus.key_down_mask   = mask;
      req_bus.octave_up_key   = up;
      req_bus.octave_down_key = dn;
      req_bus.host_blocked    = blk;
      req_bus.channel_valid   = chv;
      req_bus.channel         = chan;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      if (sender_burst > 0) begin
         sender_burst--;
      end else begin
         if ($urandom_range(0, 9) == 0) sender_burst = $urandom_range(10, 40);
         gap = gap_len();
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Drop valid, wait for every due event, then let a silent tick finish
   task automatic drain_events();
      req_bus.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic set_config(input logic en, input logic [PITCH_W-1:0] root);
      drain_events();
      write_csr(CSR_ENABLE, CSR_DATA_W'(en));
      write_csr(CSR_ROOT_NOTE, CSR_DATA_W'(root));
   endtask

   // Random ticks: mostly a few keys change; a nonzero bias drifts the octave keys one way
   task automatic random_ticks(input int bias, input int count);
      int  r;
      int  up_pct;
      int  dn_pct;
      logic blk;
      logic chv;
      up_pct = (bias > 0) ? 35 : (bias < 0) ? 12 : 20;
      dn_pct = (bias < 0) ? 35 : (bias > 0) ? 12 : 20;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            repeat ($urandom_range(1, 3)) begin
               scan_mask[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
            end
         end else if (r < 82) begin
            scan_mask = NUM_KEYS'($urandom_range(0, (1 << NUM_KEYS) - 1));
         end else if (r < 88) begin
            scan_mask = '0;
         end else if (r < 94) begin
            scan_mask = '1;
         end
         if ($urandom_range(0, 99) < up_pct) scan_up = ~scan_up;
         if ($urandom_range(0, 99) < dn_pct) scan_dn = ~scan_dn;
         if ($urandom_range(0, 9) == 0) begin
            scan_channel = CHANNEL_W'($urandom_range(0, 255));
         end
         blk = ($urandom_range(0, 99) < 5);
         chv = ($urandom_range(0, 99) >= 5);
         send_tick(scan_mask, scan_up, scan_dn, blk, chv, scan_channel);
      end
   endtask

   // Event channel back-pressure: random stalls, ready stretches, long hold-off
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      ready_burst   = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (rsp_hold_cycles - 1) @(negedge clock);
            rsp_hold_cycles = 0;
         end else if (ready_burst > 0) begin
            rsp_bus.ready = 1'b1;
            ready_burst--;
         end else begin
            stall = gap_len();
            if (stall == 0) begin
               rsp_bus.ready = 1'b1;
               if ($urandom_range(0, 7) == 0) ready_burst = $urandom_range(10, 50);
            end else begin
               rsp_bus.ready = 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   // Cap the run length
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL key_scan_note_event_generator_top");
      $finish;
   end

   initial begin
      logic [NUM_KEYS-1:0] ramp_mask;
      reset                   = 1'b1;
      csr_write_enable        = 1'b0;
      csr_index               = CSR_ENABLE;
      csr_write_data          = '0;
      req_bus.valid           = 1'b0;
      req_bus.key_down_mask   = '0;
      req_bus.octave_up_key   = 1'b0;
      req_bus.octave_down_key = 1'b0;
      req_bus.host_blocked    = 1'b0;
      req_bus.channel_valid   = 1'b0;
      req_bus.channel         = '0;
      sender_burst            = 0;
      rsp_hold_cycles         = 0;
      scan_mask               = '0;
      scan_up                 = 1'b0;
      scan_dn                 = 1'b0;
      scan_channel            = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: all keys on and off, repeat tick, octave keys together
      send_tick('1, 1'b0, 1'b0, 1'b0, 1'b1, 8'hFF);
      send_tick('1, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
      send_tick('0, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00);
      send_tick(NUM_KEYS'(12'h555), 1'b1, 1'b0, 1'b0, 1'b1, 8'h5A);
      send_tick(NUM_KEYS'(12'hAAA), 1'b0, 1'b1, 1'b0, 1'b1, 8'hA5);
      // Host blocked releases, then no channel with nothing held
      send_tick(NUM_KEYS'(12'hAAA), 1'b0, 1'b0, 1'b1, 1'b1, 8'h33);
      send_tick(NUM_KEYS'(12'hAAA), 1'b0, 1'b0, 1'b0, 1'b0, 8'h33);
      send_tick(NUM_KEYS'(12'hAAA), 1'b1, 1'b0, 1'b0, 1'b1, 8'hC3);

      // Disable by register write: the next tick releases everything
      drain_events();
      write_csr(CSR_ENABLE, CSR_DATA_W'(0));
      send_tick(NUM_KEYS'(12'hAAA), 1'b0, 1'b0, 1'b0, 1'b1, 8'h11);

      // Top root note: climb the octave past its limit while adding keys
      set_config(1'b1, PITCH_W'(PITCH_MAX));
      ramp_mask = '0;
      for (int s = 0; s < NUM_KEYS; s++) begin
         ramp_mask = {ramp_mask[NUM_KEYS-2:0], 1'b1};
         send_tick(ramp_mask, (s % 2 == 0), 1'b0, 1'b0, 1'b1, CHANNEL_W'(s * 21));
      end
      send_tick('0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);

      // Random phases across register settings
      set_config(1'b1, PITCH_W'(ROOT_RESET));
      random_ticks(1, 40);
      set_config(1'b1, '0);
      rsp_hold_cycles = 400;
      random_ticks(-1, 40);
      set_config(1'b1, PITCH_W'(PITCH_MAX));
      random_ticks(1, 20);
      drain_events();
      random_ticks(1, 20);
      set_config(1'b0, PITCH_W'(ROOT_RESET));
      random_ticks(0, 20);
      set_config(1'b1, PITCH_W'($urandom_range(0, PITCH_MAX)));
      random_ticks(0, 40);
      set_config(1'b1, PITCH_W'(PITCH_MAX));
      random_ticks(-1, 40);
      set_config(1'b1, '0);
      random_ticks(-1, 40);

      drain_events();
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS key_scan_note_event_generator_top");
      end else begin
         $display("FAIL key_scan_note_event_generator_top");
      end
      $finish;
   end

endmodule

`default_nettype wire
